[rtl/bf_pkg.sv]
// Shared types, codes and initial subkey and S-box tables for the Blowfish cipher.
`default_nettype none
package bf_pkg;

    // Request modes carried in the input tuser field.
    localparam logic [1:0] MODE_ENC    = 2'd0;
    localparam logic [1:0] MODE_DEC    = 2'd1;
    localparam logic [1:0] MODE_EXPAND = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_KEY_LEN = 3'd7;

    localparam int NUM_SUBKEYS = 18;
    localparam int NUM_KEY_WORDS = 7;
    localparam int SBOX_WORDS = 1024;
    // Encryptions that refill the subkeys, and the total per key expansion.
    localparam int SUBKEY_ENCS = NUM_SUBKEYS / 2;
    localparam int EXPAND_ENCS = SUBKEY_ENCS + SBOX_WORDS / 2;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_KEYX,
        ST_RND_A,
        ST_RND_B,
        ST_FIN,
        ST_WR,
        ST_DONE
    } bf_state_t;

    localparam logic [31:0] P_INIT [NUM_SUBKEYS] = '{
        32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
        32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89,
        32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
        32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917,
        32'h9216D5D9, 32'h8979FB1B
    };

    localparam logic [31:0] SBOX_INIT [SBOX_WORDS] = '{
        // S-box 0
        32'hD1310BA6, 32'h98DFB5AC, 32'h2FFD72DB, 32'hD01ADFB7,
        32'hB8E1AFED, 32'h6A267E96, 32'hBA7C9045, 32'hF12C7F99,
        32'h24A19947, 32'hB3916CF7, 32'h0801F2E2, 32'h858EFC16,
        32'h636920D8, 32'h71574E69, 32'hA458FEA3, 32'hF4933D7E,
        32'h0D95748F, 32'h728EB658, 32'h718BCD58, 32'h82154AEE,
        32'h7B54A41D, 32'hC25A59B5, 32'h9C30D539, 32'h2AF26013,
        32'hC5D1B023, 32'h286085F0, 32'hCA417918, 32'hB8DB38EF,
        32'h8E79DCB0, 32'h603A180E, 32'h6C9E0E8B, 32'hB01E8A3E,
        32'hD71577C1, 32'hBD314B27, 32'h78AF2FDA, 32'h55605C60,
        32'hE65525F3, 32'hAA55AB94, 32'h57489862, 32'h63E81440,
        32'h55CA396A, 32'h2AAB10B6, 32'hB4CC5C34, 32'h1141E8CE,
        32'hA15486AF, 32'h7C72E993, 32'hB3EE1411, 32'h636FBC2A,
        32'h2BA9C55D, 32'h741831F6, 32'hCE5C3E16, 32'h9B87931E,
        32'hAFD6BA33, 32'h6C24CF5C, 32'h7A325381, 32'h28958677,
        32'h3B8F4898, 32'h6B4BB9AF, 32'hC4BFE81B, 32'h66282193,
        32'h61D809CC, 32'hFB21A991, 32'h487CAC60, 32'h5DEC8032,
        32'hEF845D5D, 32'hE98575B1, 32'hDC262302, 32'hEB651B88,
        32'h23893E81, 32'hD396ACC5, 32'h0F6D6FF3, 32'h83F44239,
        32'h2E0B4482, 32'hA4842004, 32'h69C8F04A, 32'h9E1F9B5E,
        32'h21C66842, 32'hF6E96C9A, 32'h670C9C61, 32'hABD388F0,
        32'h6A51A0D2, 32'hD8542F68, 32'h960FA728, 32'hAB5133A3,
        32'h6EEF0B6C, 32'h137A3BE4, 32'hBA3BF050, 32'h7EFB2A98,
        32'hA1F1651D, 32'h39AF0176, 32'h66CA593E, 32'h82430E88,
        32'h8CEE8619, 32'h456F9FB4, 32'h7D84A5C3, 32'h3B8B5EBE,
        32'hE06F75D8, 32'h85C12073, 32'h401A449F, 32'h56C16AA6,
        32'h4ED3AA62, 32'h363F7706, 32'h1BFEDF72, 32'h429B023D,
        32'h37D0D724, 32'hD00A1248, 32'hDB0FEAD3, 32'h49F1C09B,
        32'h075372C9, 32'h80991B7B, 32'h25D479D8, 32'hF6E8DEF7,
        32'hE3FE501A, 32'hB6794C3B, 32'h976CE0BD, 32'h04C006BA,
        32'hC1A94FB6, 32'h409F60C4, 32'h5E5C9EC2, 32'h196A2463,
        32'h68FB6FAF, 32'h3E6C53B5, 32'h1339B2EB, 32'h3B52EC6F,
        32'h6DFC511F, 32'h9B30952C, 32'hCC814544, 32'hAF5EBD09,
        32'hBEE3D004, 32'hDE334AFD, 32'h660F2807, 32'h192E4BB3,
        32'hC0CBA857, 32'h45C8740F, 32'hD20B5F39, 32'hB9D3FBDB,
        32'h5579C0BD, 32'h1A60320A, 32'hD6A100C6, 32'h402C7279,
        32'h679F25FE, 32'hFB1FA3CC, 32'h8EA5E9F8, 32'hDB3222F8,
        32'h3C7516DF, 32'hFD616B15, 32'h2F501EC8, 32'hAD0552AB,
        32'h323DB5FA, 32'hFD238760, 32'h53317B48, 32'h3E00DF82,
        32'h9E5C57BB, 32'hCA6F8CA0, 32'h1A87562E, 32'hDF1769DB,
        32'hD542A8F6, 32'h287EFFC3, 32'hAC6732C6, 32'h8C4F5573,
        32'h695B27B0, 32'hBBCA58C8, 32'hE1FFA35D, 32'hB8F011A0,
        32'h10FA3D98, 32'hFD2183B8, 32'h4AFCB56C, 32'h2DD1D35B,
        32'h9A53E479, 32'hB6F84565, 32'hD28E49BC, 32'h4BFB9790,
        32'hE1DDF2DA, 32'hA4CB7E33, 32'h62FB1341, 32'hCEE4C6E8,
        32'hEF20CADA, 32'h36774C01, 32'hD07E9EFE, 32'h2BF11FB4,
        32'h95DBDA4D, 32'hAE909198, 32'hEAAD8E71, 32'h6B93D5A0,
        32'hD08ED1D0, 32'hAFC725E0, 32'h8E3C5B2F, 32'h8E7594B7,
        32'h8FF6E2FB, 32'hF2122B64, 32'h8888B812, 32'h900DF01C,
        32'h4FAD5EA0, 32'h688FC31C, 32'hD1CFF191, 32'hB3A8C1AD,
        32'h2F2F2218, 32'hBE0E1777, 32'hEA752DFE, 32'h8B021FA1,
        32'hE5A0CC0F, 32'hB56F74E8, 32'h18ACF3D6, 32'hCE89E299,
        32'hB4A84FE0, 32'hFD13E0B7, 32'h7CC43B81, 32'hD2ADA8D9,
        32'h165FA266, 32'h80957705, 32'h93CC7314, 32'h211A1477,
        32'hE6AD2065, 32'h77B5FA86, 32'hC75442F5, 32'hFB9D35CF,
        32'hEBCDAF0C, 32'h7B3E89A0, 32'hD6411BD3, 32'hAE1E7E49,
        32'h00250E2D, 32'h2071B35E, 32'h226800BB, 32'h57B8E0AF,
        32'h2464369B, 32'hF009B91E, 32'h5563911D, 32'h59DFA6AA,
        32'h78C14389, 32'hD95A537F, 32'h207D5BA2, 32'h02E5B9C5,
        32'h83260376, 32'h6295CFA9, 32'h11C81968, 32'h4E734A41,
        32'hB3472DCA, 32'h7B14A94A, 32'h1B510052, 32'h9A532915,
        32'hD60F573F, 32'hBC9BC6E4, 32'h2B60A476, 32'h81E67400,
        32'h08BA6FB5, 32'h571BE91F, 32'hF296EC6B, 32'h2A0DD915,
        32'hB6636521, 32'hE7B9F9B6, 32'hFF34052E, 32'hC5855664,
        32'h53B02D5D, 32'hA99F8FA1, 32'h08BA4799, 32'h6E85076A,
        // S-box 1
        32'h4B7A70E9, 32'hB5B32944, 32'hDB75092E, 32'hC4192623,
        32'hAD6EA6B0, 32'h49A7DF7D, 32'h9CEE60B8, 32'h8FEDB266,
        32'hECAA8C71, 32'h699A17FF, 32'h5664526C, 32'hC2B19EE1,
        32'h193602A5, 32'h75094C29, 32'hA0591340, 32'hE4183A3E,
        32'h3F54989A, 32'h5B429D65, 32'h6B8FE4D6, 32'h99F73FD6,
        32'hA1D29C07, 32'hEFE830F5, 32'h4D2D38E6, 32'hF0255DC1,
        32'h4CDD2086, 32'h8470EB26, 32'h6382E9C6, 32'h021ECC5E,
        32'h09686B3F, 32'h3EBAEFC9, 32'h3C971814, 32'h6B6A70A1,
        32'h687F3584, 32'h52A0E286, 32'hB79C5305, 32'hAA500737,
        32'h3E07841C, 32'h7FDEAE5C, 32'h8E7D44EC, 32'h5716F2B8,
        32'hB03ADA37, 32'hF0500C0D, 32'hF01C1F04, 32'h0200B3FF,
        32'hAE0CF51A, 32'h3CB574B2, 32'h25837A58, 32'hDC0921BD,
        32'hD19113F9, 32'h7CA92FF6, 32'h94324773, 32'h22F54701,
        32'h3AE5E581, 32'h37C2DADC, 32'hC8B57634, 32'h9AF3DDA7,
        32'hA9446146, 32'h0FD0030E, 32'hECC8C73E, 32'hA4751E41,
        32'hE238CD99, 32'h3BEA0E2F, 32'h3280BBA1, 32'h183EB331,
        32'h4E548B38, 32'h4F6DB908, 32'h6F420D03, 32'hF60A04BF,
        32'h2CB81290, 32'h24977C79, 32'h5679B072, 32'hBCAF89AF,
        32'hDE9A771F, 32'hD9930810, 32'hB38BAE12, 32'hDCCF3F2E,
        32'h5512721F, 32'h2E6B7124, 32'h501ADDE6, 32'h9F84CD87,
        32'h7A584718, 32'h7408DA17, 32'hBC9F9ABC, 32'hE94B7D8C,
        32'hEC7AEC3A, 32'hDB851DFA, 32'h63094366, 32'hC464C3D2,
        32'hEF1C1847, 32'h3215D908, 32'hDD433B37, 32'h24C2BA16,
        32'h12A14D43, 32'h2A65C451, 32'h50940002, 32'h133AE4DD,
        32'h71DFF89E, 32'h10314E55, 32'h81AC77D6, 32'h5F11199B,
        32'h043556F1, 32'hD7A3C76B, 32'h3C11183B, 32'h5924A509,
        32'hF28FE6ED, 32'h97F1FBFA, 32'h9EBABF2C, 32'h1E153C6E,
        32'h86E34570, 32'hEAE96FB1, 32'h860E5E0A, 32'h5A3E2AB3,
        32'h771FE71C, 32'h4E3D06FA, 32'h2965DCB9, 32'h99E71D0F,
        32'h803E89D6, 32'h5266C825, 32'h2E4CC978, 32'h9C10B36A,
        32'hC6150EBA, 32'h94E2EA78, 32'hA5FC3C53, 32'h1E0A2DF4,
        32'hF2F74EA7, 32'h361D2B3D, 32'h1939260F, 32'h19C27960,
        32'h5223A708, 32'hF71312B6, 32'hEBADFE6E, 32'hEAC31F66,
        32'hE3BC4595, 32'hA67BC883, 32'hB17F37D1, 32'h018CFF28,
        32'hC332DDEF, 32'hBE6C5AA5, 32'h65582185, 32'h68AB9802,
        32'hEECEA50F, 32'hDB2F953B, 32'h2AEF7DAD, 32'h5B6E2F84,
        32'h1521B628, 32'h29076170, 32'hECDD4775, 32'h619F1510,
        32'h13CCA830, 32'hEB61BD96, 32'h0334FE1E, 32'hAA0363CF,
        32'hB5735C90, 32'h4C70A239, 32'hD59E9E0B, 32'hCBAADE14,
        32'hEECC86BC, 32'h60622CA7, 32'h9CAB5CAB, 32'hB2F3846E,
        32'h648B1EAF, 32'h19BDF0CA, 32'hA02369B9, 32'h655ABB50,
        32'h40685A32, 32'h3C2AB4B3, 32'h319EE9D5, 32'hC021B8F7,
        32'h9B540B19, 32'h875FA099, 32'h95F7997E, 32'h623D7DA8,
        32'hF837889A, 32'h97E32D77, 32'h11ED935F, 32'h16681281,
        32'h0E358829, 32'hC7E61FD6, 32'h96DEDFA1, 32'h7858BA99,
        32'h57F584A5, 32'h1B227263, 32'h9B83C3FF, 32'h1AC24696,
        32'hCDB30AEB, 32'h532E3054, 32'h8FD948E4, 32'h6DBC3128,
        32'h58EBF2EF, 32'h34C6FFEA, 32'hFE28ED61, 32'hEE7C3C73,
        32'h5D4A14D9, 32'hE864B7E3, 32'h42105D14, 32'h203E13E0,
        32'h45EEE2B6, 32'hA3AAABEA, 32'hDB6C4F15, 32'hFACB4FD0,
        32'hC742F442, 32'hEF6ABBB5, 32'h654F3B1D, 32'h41CD2105,
        32'hD81E799E, 32'h86854DC7, 32'hE44B476A, 32'h3D816250,
        32'hCF62A1F2, 32'h5B8D2646, 32'hFC8883A0, 32'hC1C7B6A3,
        32'h7F1524C3, 32'h69CB7492, 32'h47848A0B, 32'h5692B285,
        32'h095BBF00, 32'hAD19489D, 32'h1462B174, 32'h23820E00,
        32'h58428D2A, 32'h0C55F5EA, 32'h1DADF43E, 32'h233F7061,
        32'h3372F092, 32'h8D937E41, 32'hD65FECF1, 32'h6C223BDB,
        32'h7CDE3759, 32'hCBEE7460, 32'h4085F2A7, 32'hCE77326E,
        32'hA6078084, 32'h19F8509E, 32'hE8EFD855, 32'h61D99735,
        32'hA969A7AA, 32'hC50C06C2, 32'h5A04ABFC, 32'h800BCADC,
        32'h9E447A2E, 32'hC3453484, 32'hFDD56705, 32'h0E1E9EC9,
        32'hDB73DBD3, 32'h105588CD, 32'h675FDA79, 32'hE3674340,
        32'hC5C43465, 32'h713E38D8, 32'h3D28F89E, 32'hF16DFF20,
        32'h153E21E7, 32'h8FB03D4A, 32'hE6E39F2B, 32'hDB83ADF7,
        // S-box 2
        32'hE93D5A68, 32'h948140F7, 32'hF64C261C, 32'h94692934,
        32'h411520F7, 32'h7602D4F7, 32'hBCF46B2E, 32'hD4A20068,
        32'hD4082471, 32'h3320F46A, 32'h43B7D4B7, 32'h500061AF,
        32'h1E39F62E, 32'h97244546, 32'h14214F74, 32'hBF8B8840,
        32'h4D95FC1D, 32'h96B591AF, 32'h70F4DDD3, 32'h66A02F45,
        32'hBFBC09EC, 32'h03BD9785, 32'h7FAC6DD0, 32'h31CB8504,
        32'h96EB27B3, 32'h55FD3941, 32'hDA2547E6, 32'hABCA0A9A,
        32'h28507825, 32'h530429F4, 32'h0A2C86DA, 32'hE9B66DFB,
        32'h68DC1462, 32'hD7486900, 32'h680EC0A4, 32'h27A18DEE,
        32'h4F3FFEA2, 32'hE887AD8C, 32'hB58CE006, 32'h7AF4D6B6,
        32'hAACE1E7C, 32'hD3375FEC, 32'hCE78A399, 32'h406B2A42,
        32'h20FE9E35, 32'hD9F385B9, 32'hEE39D7AB, 32'h3B124E8B,
        32'h1DC9FAF7, 32'h4B6D1856, 32'h26A36631, 32'hEAE397B2,
        32'h3A6EFA74, 32'hDD5B4332, 32'h6841E7F7, 32'hCA7820FB,
        32'hFB0AF54E, 32'hD8FEB397, 32'h454056AC, 32'hBA489527,
        32'h55533A3A, 32'h20838D87, 32'hFE6BA9B7, 32'hD096954B,
        32'h55A867BC, 32'hA1159A58, 32'hCCA92963, 32'h99E1DB33,
        32'hA62A4A56, 32'h3F3125F9, 32'h5EF47E1C, 32'h9029317C,
        32'hFDF8E802, 32'h04272F70, 32'h80BB155C, 32'h05282CE3,
        32'h95C11548, 32'hE4C66D22, 32'h48C1133F, 32'hC70F86DC,
        32'h07F9C9EE, 32'h41041F0F, 32'h404779A4, 32'h5D886E17,
        32'h325F51EB, 32'hD59BC0D1, 32'hF2BCC18F, 32'h41113564,
        32'h257B7834, 32'h602A9C60, 32'hDFF8E8A3, 32'h1F636C1B,
        32'h0E12B4C2, 32'h02E1329E, 32'hAF664FD1, 32'hCAD18115,
        32'h6B2395E0, 32'h333E92E1, 32'h3B240B62, 32'hEEBEB922,
        32'h85B2A20E, 32'hE6BA0D99, 32'hDE720C8C, 32'h2DA2F728,
        32'hD0127845, 32'h95B794FD, 32'h647D0862, 32'hE7CCF5F0,
        32'h5449A36F, 32'h877D48FA, 32'hC39DFD27, 32'hF33E8D1E,
        32'h0A476341, 32'h992EFF74, 32'h3A6F6EAB, 32'hF4F8FD37,
        32'hA812DC60, 32'hA1EBDDF8, 32'h991BE14C, 32'hDB6E6B0D,
        32'hC67B5510, 32'h6D672C37, 32'h2765D43B, 32'hDCD0E804,
        32'hF1290DC7, 32'hCC00FFA3, 32'hB5390F92, 32'h690FED0B,
        32'h667B9FFB, 32'hCEDB7D9C, 32'hA091CF0B, 32'hD9155EA3,
        32'hBB132F88, 32'h515BAD24, 32'h7B9479BF, 32'h763BD6EB,
        32'h37392EB3, 32'hCC115979, 32'h8026E297, 32'hF42E312D,
        32'h6842ADA7, 32'hC66A2B3B, 32'h12754CCC, 32'h782EF11C,
        32'h6A124237, 32'hB79251E7, 32'h06A1BBE6, 32'h4BFB6350,
        32'h1A6B1018, 32'h11CAEDFA, 32'h3D25BDD8, 32'hE2E1C3C9,
        32'h44421659, 32'h0A121386, 32'hD90CEC6E, 32'hD5ABEA2A,
        32'h64AF674E, 32'hDA86A85F, 32'hBEBFE988, 32'h64E4C3FE,
        32'h9DBC8057, 32'hF0F7C086, 32'h60787BF8, 32'h6003604D,
        32'hD1FD8346, 32'hF6381FB0, 32'h7745AE04, 32'hD736FCCC,
        32'h83426B33, 32'hF01EAB71, 32'hB0804187, 32'h3C005E5F,
        32'h77A057BE, 32'hBDE8AE24, 32'h55464299, 32'hBF582E61,
        32'h4E58F48F, 32'hF2DDFDA2, 32'hF474EF38, 32'h8789BDC2,
        32'h5366F9C3, 32'hC8B38E74, 32'hB475F255, 32'h46FCD9B9,
        32'h7AEB2661, 32'h8B1DDF84, 32'h846A0E79, 32'h915F95E2,
        32'h466E598E, 32'h20B45770, 32'h8CD55591, 32'hC902DE4C,
        32'hB90BACE1, 32'hBB8205D0, 32'h11A86248, 32'h7574A99E,
        32'hB77F19B6, 32'hE0A9DC09, 32'h662D09A1, 32'hC4324633,
        32'hE85A1F02, 32'h09F0BE8C, 32'h4A99A025, 32'h1D6EFE10,
        32'h1AB93D1D, 32'h0BA5A4DF, 32'hA186F20F, 32'h2868F169,
        32'hDCB7DA83, 32'h573906FE, 32'hA1E2CE9B, 32'h4FCD7F52,
        32'h50115E01, 32'hA70683FA, 32'hA002B5C4, 32'h0DE6D027,
        32'h9AF88C27, 32'h773F8641, 32'hC3604C06, 32'h61A806B5,
        32'hF0177A28, 32'hC0F586E0, 32'h006058AA, 32'h30DC7D62,
        32'h11E69ED7, 32'h2338EA63, 32'h53C2DD94, 32'hC2C21634,
        32'hBBCBEE56, 32'h90BCB6DE, 32'hEBFC7DA1, 32'hCE591D76,
        32'h6F05E409, 32'h4B7C0188, 32'h39720A3D, 32'h7C927C24,
        32'h86E3725F, 32'h724D9DB9, 32'h1AC15BB4, 32'hD39EB8FC,
        32'hED545578, 32'h08FCA5B5, 32'hD83D7CD3, 32'h4DAD0FC4,
        32'h1E50EF5E, 32'hB161E6F8, 32'hA28514D9, 32'h6C51133C,
        32'h6FD5C7E7, 32'h56E14EC4, 32'h362ABFCE, 32'hDDC6C837,
        32'hD79A3234, 32'h92638212, 32'h670EFA8E, 32'h406000E0,
        // S-box 3
        32'h3A39CE37, 32'hD3FAF5CF, 32'hABC27737, 32'h5AC52D1B,
        32'h5CB0679E, 32'h4FA33742, 32'hD3822740, 32'h99BC9BBE,
        32'hD5118E9D, 32'hBF0F7315, 32'hD62D1C7E, 32'hC700C47B,
        32'hB78C1B6B, 32'h21A19045, 32'hB26EB1BE, 32'h6A366EB4,
        32'h5748AB2F, 32'hBC946E79, 32'hC6A376D2, 32'h6549C2C8,
        32'h530FF8EE, 32'h468DDE7D, 32'hD5730A1D, 32'h4CD04DC6,
        32'h2939BBDB, 32'hA9BA4650, 32'hAC9526E8, 32'hBE5EE304,
        32'hA1FAD5F0, 32'h6A2D519A, 32'h63EF8CE2, 32'h9A86EE22,
        32'hC089C2B8, 32'h43242EF6, 32'hA51E03AA, 32'h9CF2D0A4,
        32'h83C061BA, 32'h9BE96A4D, 32'h8FE51550, 32'hBA645BD6,
        32'h2826A2F9, 32'hA73A3AE1, 32'h4BA99586, 32'hEF5562E9,
        32'hC72FEFD3, 32'hF752F7DA, 32'h3F046F69, 32'h77FA0A59,
        32'h80E4A915, 32'h87B08601, 32'h9B09E6AD, 32'h3B3EE593,
        32'hE990FD5A, 32'h9E34D797, 32'h2CF0B7D9, 32'h022B8B51,
        32'h96D5AC3A, 32'h017DA67D, 32'hD1CF3ED6, 32'h7C7D2D28,
        32'h1F9F25CF, 32'hADF2B89B, 32'h5AD6B472, 32'h5A88F54C,
        32'hE029AC71, 32'hE019A5E6, 32'h47B0ACFD, 32'hED93FA9B,
        32'hE8D3C48D, 32'h283B57CC, 32'hF8D56629, 32'h79132E28,
        32'h785F0191, 32'hED756055, 32'hF7960E44, 32'hE3D35E8C,
        32'h15056DD4, 32'h88F46DBA, 32'h03A16125, 32'h0564F0BD,
        32'hC3EB9E15, 32'h3C9057A2, 32'h97271AEC, 32'hA93A072A,
        32'h1B3F6D9B, 32'h1E6321F5, 32'hF59C66FB, 32'h26DCF319,
        32'h7533D928, 32'hB155FDF5, 32'h03563482, 32'h8ABA3CBB,
        32'h28517711, 32'hC20AD9F8, 32'hABCC5167, 32'hCCAD925F,
        32'h4DE81751, 32'h3830DC8E, 32'h379D5862, 32'h9320F991,
        32'hEA7A90C2, 32'hFB3E7BCE, 32'h5121CE64, 32'h774FBE32,
        32'hA8B6E37E, 32'hC3293D46, 32'h48DE5369, 32'h6413E680,
        32'hA2AE0810, 32'hDD6DB224, 32'h69852DFD, 32'h09072166,
        32'hB39A460A, 32'h6445C0DD, 32'h586CDECF, 32'h1C20C8AE,
        32'h5BBEF7DD, 32'h1B588D40, 32'hCCD2017F, 32'h6BB4E3BB,
        32'hDDA26A7E, 32'h3A59FF45, 32'h3E350A44, 32'hBCB4CDD5,
        32'h72EACEA8, 32'hFA6484BB, 32'h8D6612AE, 32'hBF3C6F47,
        32'hD29BE463, 32'h542F5D9E, 32'hAEC2771B, 32'hF64E6370,
        32'h740E0D8D, 32'hE75B1357, 32'hF8721671, 32'hAF537D5D,
        32'h4040CB08, 32'h4EB4E2CC, 32'h34D2466A, 32'h0115AF84,
        32'hE1B00428, 32'h95983A1D, 32'h06B89FB4, 32'hCE6EA048,
        32'h6F3F3B82, 32'h3520AB82, 32'h011A1D4B, 32'h277227F8,
        32'h611560B1, 32'hE7933FDC, 32'hBB3A792B, 32'h344525BD,
        32'hA08839E1, 32'h51CE794B, 32'h2F32C9B7, 32'hA01FBAC9,
        32'hE01CC87E, 32'hBCC7D1F6, 32'hCF0111C3, 32'hA1E8AAC7,
        32'h1A908749, 32'hD44FBD9A, 32'hD0DADECB, 32'hD50ADA38,
        32'h0339C32A, 32'hC6913667, 32'h8DF9317C, 32'hE0B12B4F,
        32'hF79E59B7, 32'h43F5BB3A, 32'hF2D519FF, 32'h27D9459C,
        32'hBF97222C, 32'h15E6FC2A, 32'h0F91FC71, 32'h9B941525,
        32'hFAE59361, 32'hCEB69CEB, 32'hC2A86459, 32'h12BAA8D1,
        32'hB6C1075E, 32'hE3056A0C, 32'h10D25065, 32'hCB03A442,
        32'hE0EC6E0E, 32'h1698DB3B, 32'h4C98A0BE, 32'h3278E964,
        32'h9F1F9532, 32'hE0D392DF, 32'hD3A0342B, 32'h8971F21E,
        32'h1B0A7441, 32'h4BA3348C, 32'hC5BE7120, 32'hC37632D8,
        32'hDF359F8D, 32'h9B992F2E, 32'hE60B6F47, 32'h0FE3F11D,
        32'hE54CDA54, 32'h1EDAD891, 32'hCE6279CF, 32'hCD3E7E6F,
        32'h1618B166, 32'hFD2C1D05, 32'h848FD2C5, 32'hF6FB2299,
        32'hF523F357, 32'hA6327623, 32'h93A83531, 32'h56CCCD02,
        32'hACF08162, 32'h5A75EBB5, 32'h6E163697, 32'h88D273CC,
        32'hDE966292, 32'h81B949D0, 32'h4C50901B, 32'h71C65614,
        32'hE6C6C7BD, 32'h327A140A, 32'h45E1D006, 32'hC3F27B9A,
        32'hC9AA53FD, 32'h62A80F00, 32'hBB25BFE2, 32'h35BDD2F6,
        32'h71126905, 32'hB2040222, 32'hB6CBCF7C, 32'hCD769C2B,
        32'h53113EC0, 32'h1640E3D3, 32'h38ABBD60, 32'h2547ADF0,
        32'hBA38209C, 32'hF746CE76, 32'h77AFA1C5, 32'h20756060,
        32'h85CBFE4E, 32'h8AE88DD8, 32'h7AAAF9B0, 32'h4CF9AA7E,
        32'h1948C25C, 32'h02FB8A8C, 32'h01C36AE4, 32'hD6EBE1F9,
        32'h90D4F869, 32'hA65CDEA0, 32'h3F09252D, 32'hC208E69F,
        32'hB74E6132, 32'hCE77E25B, 32'h578FDFE3, 32'h3AC372E6
    };

endpackage
`default_nettype wire

[rtl/blowfish_block_cipher.sv]
// Blowfish block cipher: S-box memory, subkey registers, round sequencer and key expansion.
// Encrypt or decrypt request: 16 rounds, each an A phase and a B phase (two S-box reads per
//   cycle on the dual-port S-box memory), plus a final step.
// Key expansion request: subkey mixing, an S-box reload from ROM, then 521 chained
//   encryptions whose results refill the subkeys and then the S-boxes.
// One request is in work at a time; a new one is taken the cycle after the previous result
//   is registered.
// After reset the S-box memory is loaded from ROM before the first request is taken.
`default_nettype none
module blowfish_block_cipher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // block_in[63:0]
    input  wire logic        s_tlast,   // last_block
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    // Result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // block_out[63:0]
    output logic             m_tlast,   // last_out
    output logic             m_tuser,   // key_done
    // Configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import bf_pkg::*;

    // S-box memory and its registered read ports
    logic [31:0] sbox_mem [SBOX_WORDS];
    logic [31:0] dout_a_reg, dout_b_reg;
    logic [9:0]  addr_a, addr_b;
    logic        mem_we;
    logic [31:0] mem_wdata;

    // Control and datapath registers
    bf_state_t   state_reg, state_next;
    logic [31:0] subkey_reg [NUM_SUBKEYS];
    logic [63:0] key_word_reg [NUM_KEY_WORDS];
    logic [5:0]  key_len_reg;
    logic [1:0]  mode_reg;
    logic        last_reg;
    logic [31:0] xl_reg, xr_reg, ab_reg;
    logic        first_reg;
    logic [3:0]  rnd_reg;
    logic [10:0] fill_cnt_reg;
    logic [31:0] rom_data_reg;
    logic        fill_exp_reg;
    logic [4:0]  kx_cnt_reg;
    logic [5:0]  pos_reg;
    logic [9:0]  enc_cnt_reg;
    logic [63:0] res_reg;
    logic        m_tvalid_reg, m_tlast_reg, m_tuser_reg;
    logic [63:0] m_tdata_reg;

    // Combinational datapath values
    logic [31:0] f_val, cur_l, cur_r, t_val, rkey;
    logic [4:0]  rkey_idx;
    logic        dec;
    logic [31:0] fin_l;
    logic [63:0] fin_res;
    logic [5:0]  len_c;
    logic [5:0]  p1, p2, p3, p4;
    logic [31:0] kx_word;
    logic [9:0]  sb_idx;
    logic        fill_end, exp_last, sub_phase, out_free;

    function automatic logic [5:0] inc_pos(input logic [5:0] p, input logic [5:0] len);
        logic [5:0] n;
        n = p + 6'd1;
        return (n == len) ? 6'd0 : n;
    endfunction

    function automatic logic [7:0] key_byte(input logic [63:0] w, input logic [2:0] b);
        return 8'(w >> {~b, 3'b000});
    endfunction

    // Round function, key mixing and final whitening
    always_comb begin
        dec      = (mode_reg == MODE_DEC);
        rkey_idx = dec ? 5'(5'd17 - {1'b0, rnd_reg}) : {1'b0, rnd_reg};
        rkey     = subkey_reg[rkey_idx];
        f_val    = (ab_reg ^ dout_a_reg) + dout_b_reg;
        if (first_reg) begin
            cur_l = xl_reg;
            cur_r = xr_reg;
        end else begin
            cur_l = xr_reg ^ f_val;
            cur_r = xl_reg;
        end
        t_val = cur_l ^ rkey;
        fin_l = xr_reg ^ f_val;
        if (dec) begin
            fin_res = {xl_reg ^ subkey_reg[0], fin_l ^ subkey_reg[1]};
        end else begin
            fin_res = {xl_reg ^ subkey_reg[17], fin_l ^ subkey_reg[16]};
        end
        // Key length clamped to 1..56, four bytes taken cyclically
        if (key_len_reg == 6'd0) begin
            len_c = 6'd1;
        end else if (key_len_reg > 6'd56) begin
            len_c = 6'd56;
        end else begin
            len_c = key_len_reg;
        end
        p1 = inc_pos(pos_reg, len_c);
        p2 = inc_pos(p1, len_c);
        p3 = inc_pos(p2, len_c);
        p4 = inc_pos(p3, len_c);
        kx_word = {key_byte(key_word_reg[pos_reg[5:3]], pos_reg[2:0]),
                   key_byte(key_word_reg[p1[5:3]], p1[2:0]),
                   key_byte(key_word_reg[p2[5:3]], p2[2:0]),
                   key_byte(key_word_reg[p3[5:3]], p3[2:0])};
        sb_idx    = enc_cnt_reg - 10'(SUBKEY_ENCS);
        sub_phase = (enc_cnt_reg < 10'(SUBKEY_ENCS));
        exp_last  = (enc_cnt_reg == 10'(EXPAND_ENCS - 1));
        fill_end  = (fill_cnt_reg == 11'(SBOX_WORDS));
        out_free  = !m_tvalid_reg || m_tready;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL: begin
                if (fill_end) begin
                    state_next = fill_exp_reg ? ST_RND_A : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == MODE_ENC || s_tuser == MODE_DEC) begin
                        state_next = ST_RND_A;
                    end else if (s_tuser == MODE_EXPAND) begin
                        state_next = ST_KEYX;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_KEYX: begin
                if (kx_cnt_reg == 5'(NUM_SUBKEYS - 1)) begin
                    state_next = ST_FILL;
                end
            end
            ST_RND_A: state_next = ST_RND_B;
            ST_RND_B: state_next = (rnd_reg == 4'd15) ? ST_FIN : ST_RND_A;
            ST_FIN: begin
                if (mode_reg != MODE_EXPAND) begin
                    state_next = ST_DONE;
                end else if (sub_phase) begin
                    state_next = ST_RND_A;
                end else begin
                    state_next = ST_WR;
                end
            end
            ST_WR:   state_next = exp_last ? ST_DONE : ST_RND_A;
            ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory port control and handshake outputs
    always_comb begin
        addr_a    = '0;
        addr_b    = '0;
        mem_we    = 1'b0;
        mem_wdata = rom_data_reg;
        s_tready  = 1'b0;
        case (state_reg)
            ST_FILL: begin
                addr_a = 10'(fill_cnt_reg - 11'd1);
                mem_we = (fill_cnt_reg != 11'd0);
            end
            ST_IDLE: s_tready = 1'b1;
            ST_RND_A: begin
                addr_a = {2'd0, t_val[31:24]};
                addr_b = {2'd1, t_val[23:16]};
            end
            ST_RND_B: begin
                addr_a = {2'd2, xl_reg[15:8]};
                addr_b = {2'd3, xl_reg[7:0]};
            end
            ST_FIN: begin
                addr_a    = {sb_idx[8:0], 1'b0};
                mem_we    = (mode_reg == MODE_EXPAND) && !sub_phase;
                mem_wdata = fin_res[63:32];
            end
            ST_WR: begin
                addr_a    = {sb_idx[8:0], 1'b1};
                mem_we    = 1'b1;
                mem_wdata = res_reg[31:0];
            end
            default: begin
                addr_a = '0;
            end
        endcase
    end

    // S-box memory: one read/write port and one read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sbox_mem[addr_a] <= mem_wdata;
        end
        dout_a_reg <= sbox_mem[addr_a];
        dout_b_reg <= sbox_mem[addr_b];
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_KEY_WORDS; i++) begin
                key_word_reg[i] <= '0;
            end
            key_len_reg <= 6'd8;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_KEY_LEN) begin
                key_len_reg <= cfg_data[5:0];
            end else begin
                key_word_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // Sequencer, subkeys and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            fill_cnt_reg <= '0;
            fill_exp_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_SUBKEYS; i++) begin
                subkey_reg[i] <= P_INIT[i];
            end
        end else begin
            state_reg <= state_next;
            // A new result replaces a taken one; otherwise a taken result clears valid.
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_FILL: begin
                    rom_data_reg <= SBOX_INIT[fill_cnt_reg[9:0]];
                    fill_cnt_reg <= fill_cnt_reg + 11'd1;
                    if (fill_end) begin
                        xl_reg      <= '0;
                        xr_reg      <= '0;
                        first_reg   <= 1'b1;
                        rnd_reg     <= '0;
                        enc_cnt_reg <= '0;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg   <= s_tuser;
                        last_reg   <= s_tlast;
                        xl_reg     <= s_tdata[63:32];
                        xr_reg     <= s_tdata[31:0];
                        first_reg  <= 1'b1;
                        rnd_reg    <= '0;
                        kx_cnt_reg <= '0;
                        pos_reg    <= '0;
                        res_reg    <= '0;
                    end
                end
                ST_KEYX: begin
                    // Reload the initial subkey and mix in four key bytes
                    subkey_reg[kx_cnt_reg] <= P_INIT[kx_cnt_reg] ^ kx_word;
                    pos_reg    <= p4;
                    kx_cnt_reg <= kx_cnt_reg + 5'd1;
                    fill_cnt_reg <= '0;
                    fill_exp_reg <= 1'b1;
                end
                ST_RND_A: begin
                    xl_reg    <= t_val;
                    xr_reg    <= cur_r;
                    first_reg <= 1'b0;
                end
                ST_RND_B: begin
                    ab_reg  <= dout_a_reg + dout_b_reg;
                    rnd_reg <= rnd_reg + 4'd1;
                end
                ST_FIN: begin
                    res_reg <= fin_res;
                    if (mode_reg == MODE_EXPAND) begin
                        // Chain the next encryption from this result
                        xl_reg    <= fin_res[63:32];
                        xr_reg    <= fin_res[31:0];
                        first_reg <= 1'b1;
                        rnd_reg   <= '0;
                        if (sub_phase) begin
                            subkey_reg[{enc_cnt_reg[3:0], 1'b0}] <= fin_res[63:32];
                            subkey_reg[{enc_cnt_reg[3:0], 1'b1}] <= fin_res[31:0];
                            enc_cnt_reg <= enc_cnt_reg + 10'd1;
                        end
                    end
                end
                ST_WR: begin
                    enc_cnt_reg <= enc_cnt_reg + 10'd1;
                    if (exp_last) begin
                        res_reg <= '0;
                    end
                end
                ST_DONE: begin
                    fill_exp_reg <= 1'b0;
                    if (out_free) begin
                        m_tdata_reg  <= res_reg;
                        m_tlast_reg  <= last_reg;
                        m_tuser_reg  <= (mode_reg == MODE_EXPAND);
                    end
                end
                default: begin
                    fill_exp_reg <= fill_exp_reg;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // No S-box write may land while a round is reading the tables.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RND_A || state_reg == ST_RND_B) |-> !mem_we)
        else $error("S-box write during a round");

    // The final step follows only the second phase of the last round.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> ($past(state_reg) == ST_RND_B && rnd_reg == 4'd0))
        else $error("final step out of sequence");

    // A key expansion result carries a zero block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg) |-> (m_tdata_reg == 64'd0))
        else $error("key expansion result not zero");

    // Only one request is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while busy");

endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the Blowfish block cipher with stream request and result channels.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bf_pkg::*;

    // The unused mode code, which the block answers with a zero block and no key_done.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [63:0] block;
        logic        last;
        logic        done;
    } cipher_result_t;

    typedef struct {
        logic [1:0]  mode;
        logic [63:0] block;
        logic        last;
        logic        typed;
        logic [63:0] want_block;
        logic        want_done;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic [1:0]  s_tuser = MODE_ENC;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    // Predictor state: subkeys, S-boxes and the key registers.
    logic [31:0] subkeys [NUM_SUBKEYS];
    logic [31:0] sboxes [SBOX_WORDS];
    logic [63:0] key_words [NUM_KEY_WORDS];
    logic [5:0]  key_len;

    cipher_result_t pending_results[$];
    int          error_count = 0;
    logic        quiet = 1'b0;
    int          hold_requests = 0;
    logic [63:0] recent_cipher = '0;

    blowfish_block_cipher DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Round function over the four S-boxes.
    function automatic logic [31:0] round_mix(input logic [31:0] x);
        logic [31:0] t;
        t = sboxes[x[31:24]] + sboxes[256 + x[23:16]];
        t = t ^ sboxes[512 + x[15:8]];
        return t + sboxes[768 + x[7:0]];
    endfunction

    function automatic logic [63:0] encipher(input logic [63:0] blk);
        logic [31:0] lh, rh;
        lh = blk[63:32];
        rh = blk[31:0];
        for (int j = 0; j < 16; j += 2) begin
            lh ^= subkeys[j];
            rh ^= round_mix(lh) ^ subkeys[j + 1];
            lh ^= round_mix(rh);
        end
        return {rh ^ subkeys[17], lh ^ subkeys[16]};
    endfunction

    function automatic logic [63:0] decipher(input logic [63:0] blk);
        logic [31:0] lh, rh;
        lh = blk[63:32];
        rh = blk[31:0];
        for (int j = 17; j > 1; j -= 2) begin
            lh ^= subkeys[j];
            rh ^= round_mix(lh) ^ subkeys[j - 1];
            lh ^= round_mix(rh);
        end
        return {rh ^ subkeys[0], lh ^ subkeys[1]};
    endfunction

    function automatic void load_initial_tables();
        for (int i = 0; i < NUM_SUBKEYS; i++) subkeys[i] = P_INIT[i];
        for (int i = 0; i < SBOX_WORDS; i++) sboxes[i] = SBOX_INIT[i];
    endfunction

    // Key schedule: fresh tables, key bytes mixed into subkeys, then chained encryptions.
    function automatic void expand_key();
        int          len, pos;
        logic [31:0] w;
        logic [63:0] blk;
        len = (key_len == 0) ? 1 : (key_len > 56) ? 56 : key_len;
        pos = 0;
        blk = '0;
        load_initial_tables();
        for (int i = 0; i < NUM_SUBKEYS; i++) begin
            w = '0;
            for (int b = 0; b < 4; b++) begin
                w = {w[23:0], key_words[pos / 8][63 - 8 * (pos % 8) -: 8]};
                pos = (pos + 1) % len;
            end
            subkeys[i] ^= w;
        end
        for (int i = 0; i < NUM_SUBKEYS; i += 2) begin
            blk = encipher(blk);
            subkeys[i] = blk[63:32];
            subkeys[i + 1] = blk[31:0];
        end
        for (int i = 0; i < SBOX_WORDS; i += 2) begin
            blk = encipher(blk);
            sboxes[i] = blk[63:32];
            sboxes[i + 1] = blk[31:0];
        end
    endfunction

    function automatic cipher_result_t predict_result(input logic [1:0] mode,
                                                      input logic [63:0] blk,
                                                      input logic last);
        cipher_result_t r;
        r.block = '0;
        r.last = last;
        r.done = 1'b0;
        case (mode)
            MODE_ENC: begin
                r.block = encipher(blk);
                recent_cipher = r.block;
            end
            MODE_DEC: r.block = decipher(blk);
            MODE_EXPAND: begin
                expand_key();
                r.done = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offer one request with random gaps; the expectation is queued once it is taken.
    task automatic send_request(input logic [1:0] mode, input logic [63:0] blk,
                                input logic last, input logic typed = 1'b0,
                                input logic [63:0] want_block = '0,
                                input logic want_done = 1'b0);
        cipher_result_t r;
        while (!quiet && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= blk;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_result(mode, blk, last);
        if (typed) begin
            r.block = want_block;
            r.done = want_done;
        end
        pending_results.push_back(r);
    endtask

    // Let the block drain all outstanding results, then a few more cycles.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // The caller drops the write enable after the last write of a series.
    task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        if (idx == CFG_KEY_LEN) key_len = value[5:0];
        else key_words[idx] = value;
    endtask

    // Result side: compare each accepted result, then pick the next ready value.
    int hold_left = 0;
    int holds_seen = 0;
    always @(posedge aclk) begin
        cipher_result_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            end else begin
                w = pending_results.pop_front();
                if (m_tdata !== w.block)
                    report_mismatch($sformatf("block %h, want %h", m_tdata, w.block));
                if (m_tlast !== w.last)
                    report_mismatch($sformatf("last %b, want %b", m_tlast, w.last));
                if (m_tuser !== w.done)
                    report_mismatch($sformatf("key_done %b, want %b", m_tuser, w.done));
            end
        end
        if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= 13);
        end
    end

    directed_row_t directed [16] = '{
        '{MODE_ENC,    64'h0,                  1'b0, 1'b0, 64'h0, 1'b0},
        '{MODE_ENC,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0, 1'b0},
        '{MODE_DEC,    64'h0,                  1'b0, 1'b0, 64'h0, 1'b0},
        '{MODE_DEC,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0, 1'b0},
        '{MODE_ENC,    64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'h0, 1'b0},
        '{MODE_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'h0, 1'b0},
        '{MODE_UNUSED, 64'h0,                  1'b0, 1'b1, 64'h0, 1'b0},
        '{MODE_ENC,    64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 64'h0, 1'b0},
        '{MODE_EXPAND, 64'h0,                  1'b0, 1'b1, 64'h0, 1'b1},
        '{MODE_ENC,    64'h0,                  1'b0, 1'b0, 64'h0, 1'b0},
        '{MODE_DEC,    64'hFEDC_BA98_7654_3210, 1'b1, 1'b0, 64'h0, 1'b0},
        '{MODE_UNUSED, 64'h5A5A_A5A5_5A5A_A5A5, 1'b1, 1'b1, 64'h0, 1'b0},
        '{MODE_ENC,    64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
        '{MODE_DEC,    64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0, 64'h0, 1'b0},
        '{MODE_EXPAND, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'h0, 1'b1},
        '{MODE_ENC,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0, 1'b0}
    };

    initial begin
        int          lengths [5];
        logic [1:0]  mode;
        logic [63:0] blk;
        int          pick;
        lengths = '{56, 1, 0, 63, 0};
        for (int i = 0; i < NUM_KEY_WORDS; i++) key_words[i] = '0;
        key_len = 6'd8;
        load_initial_tables();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests under the reset key settings.
        foreach (directed[i])
            send_request(directed[i].mode, directed[i].block, directed[i].last,
                         directed[i].typed, directed[i].want_block, directed[i].want_done);

        // Random phases, each with its own key and a fresh expansion.
        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            for (int i = 0; i < NUM_KEY_WORDS; i++) begin
                if (ph == 0) blk = '1;
                else if (ph == 1) blk = '0;
                else blk = {$urandom, $urandom};
                write_register(i[2:0], blk);
            end
            write_register(CFG_KEY_LEN, (ph == 4) ? 64'($urandom_range(55, 2)) : 64'(lengths[ph]));
            cfg_wr_en <= 1'b0;
            send_request(MODE_EXPAND, {$urandom, $urandom}, 1'($urandom));
            quiet <= (ph == 3);
            for (int n = 0; n < 225; n++) begin
                if (ph == 1 && n == 40) hold_requests <= hold_requests + 1;
                pick = $urandom_range(199);
                blk = {$urandom, $urandom};
                if (pick < 2) mode = MODE_EXPAND;
                else if (pick < 8) mode = MODE_UNUSED;
                else if (pick < 104) mode = MODE_ENC;
                else mode = MODE_DEC;
                // Decrypt of a fresh ciphertext should close the round trip.
                if (mode == MODE_DEC && pick < 150) blk = recent_cipher;
                send_request(mode, blk, 1'($urandom));
            end
            quiet <= 1'b0;
        end

        wait_idle();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
